@@ rtl/core/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg
// Shared sizes, command and status codes, and control structs of the sorted
// key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OCNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP_KEY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP_POS = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic load;
    logic apply;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/core/skt_ctrl.sv @@
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer: takes an item, then lets the datapath commit it once the
// output register is free.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  skt_pkg::dp_status_t dp_status_i,
  output skt_pkg::ctrl_cmd_t  ctrl_cmd_o
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_FINISH = 1'b1;

  logic state_q, state_d;

  assign in_ready_o       = (state_q == S_IDLE);
  assign ctrl_cmd_o.load  = in_valid_i && in_ready_o;
  assign ctrl_cmd_o.apply = (state_q == S_FINISH) && dp_status_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (ctrl_cmd_o.load) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (ctrl_cmd_o.apply) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/skt_datapath.sv @@
// ----------------------------------------------------------------------------
// skt_datapath
// Entry cells with compare-and-shift, item latch, match vectors and the
// output register.
// ----------------------------------------------------------------------------
module skt_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  skt_pkg::ctrl_cmd_t           ctrl_cmd_i,
  output skt_pkg::dp_status_t          dp_status_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic [skt_pkg::CMD_W-1:0]    command_i,
  input  logic [skt_pkg::KEY_W-1:0]    key_i,
  input  logic [skt_pkg::VAL_W-1:0]    value_i,
  input  logic [skt_pkg::POS_W-1:0]    position_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [skt_pkg::STAT_W-1:0]   status_o,
  output logic [skt_pkg::POS_W-1:0]    entry_position_o,
  output logic [skt_pkg::KEY_W-1:0]    key_out_o,
  output logic [skt_pkg::VAL_W-1:0]    value_out_o,
  output logic [skt_pkg::OCNT_W-1:0]   entry_count_o
);

  logic [skt_pkg::KEY_W-1:0]  keys_q [skt_pkg::DEPTH];
  logic [skt_pkg::VAL_W-1:0]  vals_q [skt_pkg::DEPTH];
  logic [skt_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       mode_q;

  logic [skt_pkg::CMD_W-1:0]  cmd_q;
  logic [skt_pkg::KEY_W-1:0]  key_q;
  logic [skt_pkg::VAL_W-1:0]  val_q;
  logic [skt_pkg::POS_W-1:0]  pos_q;
  logic [skt_pkg::DEPTH-1:0]  le_q, eq_q;

  logic                       out_valid_q;
  logic [skt_pkg::STAT_W-1:0] status_q, status_d;
  logic [skt_pkg::POS_W-1:0]  epos_q, epos_d;
  logic [skt_pkg::KEY_W-1:0]  kout_q, kout_d;
  logic [skt_pkg::VAL_W-1:0]  vout_q, vout_d;
  logic [skt_pkg::OCNT_W-1:0] ocnt_q;

  logic [skt_pkg::IDX_W-1:0]  first_gt, last_eq, first_eq, ins_pos, hit_pos, rd_idx;
  logic                       found, full, pos_ok, do_insert, do_remove;

  assign dp_status_o.out_free = !out_valid_q || out_ready_i;

  // Insert slot: first cell whose key is greater, or the first empty cell.
  always_comb begin
    first_gt = '0;
    first_eq = '0;
    for (int i = skt_pkg::DEPTH - 1; i >= 0; i--) begin
      if (!le_q[i]) first_gt = skt_pkg::IDX_W'(i);
      if (eq_q[i])  first_eq = skt_pkg::IDX_W'(i);
    end
  end

  always_comb begin
    last_eq = '0;
    for (int i = 0; i < skt_pkg::DEPTH; i++) begin
      if (eq_q[i]) last_eq = skt_pkg::IDX_W'(i);
    end
  end

  assign found     = |eq_q;
  assign full      = (count_q == skt_pkg::CNT_W'(skt_pkg::DEPTH));
  assign pos_ok    = (32'(pos_q) < 32'(count_q));
  assign ins_pos   = mode_q ? first_gt : skt_pkg::IDX_W'(count_q);
  assign hit_pos   = mode_q ? last_eq : first_eq;
  assign rd_idx    = (cmd_q == skt_pkg::CMD_LOOKUP_POS) ? skt_pkg::IDX_W'(pos_q) : hit_pos;
  assign do_insert = ctrl_cmd_i.apply && (cmd_q == skt_pkg::CMD_INSERT) && !full;
  assign do_remove = ctrl_cmd_i.apply && (cmd_q == skt_pkg::CMD_REMOVE) && found;

  always_comb begin
    status_d = skt_pkg::STAT_NOT_FOUND;
    epos_d   = '0;
    kout_d   = '0;
    vout_d   = '0;
    count_d  = count_q;
    case (cmd_q)
      skt_pkg::CMD_INSERT: begin
        if (full) begin
          status_d = skt_pkg::STAT_FULL;
        end else begin
          status_d = skt_pkg::STAT_OK;
          epos_d   = skt_pkg::POS_W'(ins_pos);
          kout_d   = key_q;
          vout_d   = val_q;
          count_d  = count_q + 1'b1;
        end
      end
      skt_pkg::CMD_LOOKUP_POS: begin
        if (pos_ok) begin
          status_d = skt_pkg::STAT_OK;
          epos_d   = pos_q;
          kout_d   = keys_q[rd_idx];
          vout_d   = vals_q[rd_idx];
        end
      end
      skt_pkg::CMD_LOOKUP_KEY, skt_pkg::CMD_REMOVE: begin
        if (found) begin
          status_d = skt_pkg::STAT_OK;
          epos_d   = skt_pkg::POS_W'(hit_pos);
          kout_d   = keys_q[rd_idx];
          vout_d   = vals_q[rd_idx];
          if (cmd_q == skt_pkg::CMD_REMOVE) count_d = count_q - 1'b1;
        end
      end
      default: status_d = skt_pkg::STAT_NOT_FOUND;
    endcase
  end

  // Item latch and per-cell compares against the stable table.
  always_ff @(posedge clk_i) begin
    if (ctrl_cmd_i.load) begin
      cmd_q <= command_i;
      key_q <= key_i;
      val_q <= value_i;
      pos_q <= position_i;
      for (int i = 0; i < skt_pkg::DEPTH; i++) begin
        le_q[i] <= (32'(i) < 32'(count_q)) && (keys_q[i] <= key_i);
        eq_q[i] <= (32'(i) < 32'(count_q)) && (keys_q[i] == key_i);
      end
    end
  end

  // Cells shift up on insert, down on remove.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < skt_pkg::DEPTH; j++) begin
      if (do_insert) begin
        if (j > int'(ins_pos)) begin
          keys_q[j] <= keys_q[(j > 0) ? j - 1 : 0];
          vals_q[j] <= vals_q[(j > 0) ? j - 1 : 0];
        end else if (j == int'(ins_pos)) begin
          keys_q[j] <= key_q;
          vals_q[j] <= val_q;
        end
      end else if (do_remove) begin
        if ((j >= int'(hit_pos)) && (j < skt_pkg::DEPTH - 1)) begin
          keys_q[j] <= keys_q[j + 1];
          vals_q[j] <= vals_q[j + 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_cmd_i.apply) begin
      status_q <= status_d;
      epos_q   <= epos_d;
      kout_q   <= kout_d;
      vout_q   <= vout_d;
      ocnt_q   <= skt_pkg::OCNT_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      mode_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (ctrl_cmd_i.apply) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign entry_position_o = epos_q;
  assign key_out_o        = kout_q;
  assign value_out_o      = vout_q;
  assign entry_count_o    = ocnt_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= skt_pkg::CNT_W'(skt_pkg::DEPTH))
    else $error("entry count above depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd_i.apply |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not grow the table");

  a_no_load_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_cmd_i.load && ctrl_cmd_i.apply))
    else $error("item taken while previous item commits");

endmodule

@@ rtl/core/sorted_key_table.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of up to 16 key/value entries: insert, lookup by key, lookup by
// position and remove by key, kept in key order or in insertion order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one command item (command,
//   key, value, position). Output channel out_valid_o/out_ready_i returns
//   one result item per command (status, entry position, key, value, count).
//   cfg_we_i/cfg_wdata_i writes sorted mode (1 sorted, 0 insertion order);
//   write it only while the table is idle.
//   An item is taken only while no earlier item is waiting to commit; the
//   item is compared against all entry cells in its accept cycle, and the
//   cells shift and the result register loads once the output register is
//   free.
//   A stalled receiver holds the result in the output register; one more item
//   can be taken meanwhile, and it waits to commit until the result is taken.
//   Reset empties the table, selects sorted mode and clears the output valid.
// ----------------------------------------------------------------------------
module sorted_key_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [skt_pkg::CMD_W-1:0]    command_i,
  input  logic [skt_pkg::KEY_W-1:0]    key_i,
  input  logic [skt_pkg::VAL_W-1:0]    value_i,
  input  logic [skt_pkg::POS_W-1:0]    position_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [skt_pkg::STAT_W-1:0]   status_o,
  output logic [skt_pkg::POS_W-1:0]    entry_position_o,
  output logic [skt_pkg::KEY_W-1:0]    key_out_o,
  output logic [skt_pkg::VAL_W-1:0]    value_out_o,
  output logic [skt_pkg::OCNT_W-1:0]   entry_count_o
);

  skt_pkg::ctrl_cmd_t  ctrl_cmd;
  skt_pkg::dp_status_t dp_status;

  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .dp_status_i (dp_status),
    .ctrl_cmd_o  (ctrl_cmd)
  );

  skt_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_cmd_i       (ctrl_cmd),
    .dp_status_o      (dp_status),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .command_i        (command_i),
    .key_i            (key_i),
    .value_i          (value_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .entry_position_o (entry_position_o),
    .key_out_o        (key_out_o),
    .value_out_o      (value_out_o),
    .entry_count_o    (entry_count_o)
  );

endmodule

@@ tb/skt_checker.sv @@
// ----------------------------------------------------------------------------
// skt_checker
// Watches the command and result channels of the sorted key table. It keeps
// its own copy of the table and the sorted-mode bit, predicts one result per
// accepted command, and compares each returned result field by field with
// the oldest prediction.
// ----------------------------------------------------------------------------
module skt_checker
  import skt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [VAL_W-1:0]    value_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [STAT_W-1:0]   status_i,
  input  logic [POS_W-1:0]    entry_position_i,
  input  logic [KEY_W-1:0]    key_out_i,
  input  logic [VAL_W-1:0]    value_out_i,
  input  logic [OCNT_W-1:0]   entry_count_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [OCNT_W-1:0] count;
  } table_result_t;

  logic [KEY_W-1:0] entry_keys [DEPTH];
  logic [VAL_W-1:0] entry_vals [DEPTH];
  int unsigned      entry_total;
  logic             sorted_sel;
  table_result_t    result_fifo [$];

  function automatic table_result_t run_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
                                                logic [VAL_W-1:0] v, logic [POS_W-1:0] p);
    table_result_t r;
    int unsigned   at;
    int unsigned   j;
    int            hit;
    r = '0;
    r.status = STAT_NOT_FOUND;
    case (cmd)
      CMD_INSERT: begin
        if (entry_total >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          at = entry_total;
          if (sorted_sel) begin
            at = 0;
            while (at < entry_total && entry_keys[at] <= k) at++;
          end
          for (j = entry_total; j > at; j--) begin
            entry_keys[j] = entry_keys[j-1];
            entry_vals[j] = entry_vals[j-1];
          end
          entry_keys[at] = k;
          entry_vals[at] = v;
          entry_total++;
          r.status   = STAT_OK;
          r.position = POS_W'(at);
          r.key      = k;
          r.value    = v;
        end
      end
      CMD_LOOKUP_POS: begin
        if (p < entry_total) begin
          r.status   = STAT_OK;
          r.position = p;
          r.key      = entry_keys[p];
          r.value    = entry_vals[p];
        end
      end
      default: begin
        hit = -1;
        for (j = 0; j < entry_total; j++) begin
          if (entry_keys[j] == k) begin
            hit = j;
            if (!sorted_sel) break;
          end
        end
        if (hit >= 0) begin
          r.status   = STAT_OK;
          r.position = POS_W'(hit);
          r.key      = entry_keys[hit];
          r.value    = entry_vals[hit];
          if (cmd == CMD_REMOVE) begin
            entry_total--;
            for (j = hit; j < entry_total; j++) begin
              entry_keys[j] = entry_keys[j+1];
              entry_vals[j] = entry_vals[j+1];
            end
          end
        end
      end
    endcase
    r.count = OCNT_W'(entry_total);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t exp_r;
    int unsigned   errs;
    errs = 0;
    if (!rst_ni) begin
      entry_total = 0;
      sorted_sel = 1'b1;
      result_fifo.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) sorted_sel = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        result_fifo.push_back(run_command(command_i, key_i, value_i, position_i));
      end
      if (out_valid_i === 1'b1 && out_ready_i) begin
        if (result_fifo.size() == 0) begin
          $error("result item with no command pending");
          errs++;
        end else begin
          exp_r = result_fifo.pop_front();
          if (status_i !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, status_i);
            errs++;
          end
          if (entry_position_i !== exp_r.position) begin
            $error("entry_position: expected %0d, actual %0d", exp_r.position,
                   entry_position_i);
            errs++;
          end
          if (key_out_i !== exp_r.key) begin
            $error("key_out: expected %h, actual %h", exp_r.key, key_out_i);
            errs++;
          end
          if (value_out_i !== exp_r.value) begin
            $error("value_out: expected %h, actual %h", exp_r.value, value_out_i);
            errs++;
          end
          if (entry_count_i !== exp_r.count) begin
            $error("entry_count: expected %0d, actual %0d", exp_r.count, entry_count_i);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o <= result_fifo.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the sorted key table: a directed pass over empty, duplicate,
// extreme-key, out-of-range and full-table cases, then random command mixes
// that fill and drain the table in both modes, switching mode with entries
// present. Both channels stall at random; a checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import skt_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_wdata_i = 1'b1;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [CMD_W-1:0]  command_i = CMD_INSERT;
  logic [KEY_W-1:0]  key_i = '0;
  logic [VAL_W-1:0]  value_i = '0;
  logic [POS_W-1:0]  position_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [STAT_W-1:0] status_o;
  logic [POS_W-1:0]  entry_position_o;
  logic [KEY_W-1:0]  key_out_o;
  logic [VAL_W-1:0]  value_out_o;
  logic [OCNT_W-1:0] entry_count_o;
  int unsigned       fail_count;
  int unsigned       pending;
  logic              calm = 1'b0;

  sorted_key_table u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .key_i            (key_i),
    .value_i          (value_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .entry_position_o (entry_position_o),
    .key_out_o        (key_out_o),
    .value_out_o      (value_out_o),
    .entry_count_o    (entry_count_o)
  );

  skt_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .command_i        (command_i),
    .key_i            (key_i),
    .value_i          (value_i),
    .position_i       (position_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_i         (status_o),
    .entry_position_i (entry_position_o),
    .key_out_i        (key_out_o),
    .value_out_i      (value_out_o),
    .entry_count_i    (entry_count_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 13);
  end

  task automatic issue_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] v, input logic [POS_W-1:0] p);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 13) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    key_i      <= k;
    value_i    <= v;
    position_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    drain_results();
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return KEY_W'($urandom);
      default: return KEY_W'($urandom_range(0, 7));
    endcase
  endfunction

  // insert_pct sets whether the table tends to fill or drain
  task automatic mixed_commands(input int unsigned n, input int unsigned insert_pct);
    int unsigned      r;
    logic [CMD_W-1:0] cmd;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) cmd = CMD_INSERT;
      else if (r < insert_pct + (100 - insert_pct) / 3) cmd = CMD_LOOKUP_KEY;
      else if (r < insert_pct + 2 * (100 - insert_pct) / 3) cmd = CMD_LOOKUP_POS;
      else cmd = CMD_REMOVE;
      issue_item(cmd, pick_key(), VAL_W'($urandom), POS_W'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mode(1'b1);

    // empty table
    issue_item(CMD_LOOKUP_KEY, 32'd5, '0, '0);
    issue_item(CMD_REMOVE, 32'd5, '0, '0);
    issue_item(CMD_LOOKUP_POS, '0, '0, 4'd0);
    // extremes and duplicate keys
    issue_item(CMD_INSERT, '1, '0, '1);
    issue_item(CMD_INSERT, '0, '1, '0);
    issue_item(CMD_INSERT, 32'd5, 32'd1, '0);
    issue_item(CMD_INSERT, 32'd5, 32'd2, '0);
    issue_item(CMD_LOOKUP_KEY, 32'd5, '0, '0);
    issue_item(CMD_LOOKUP_POS, '1, '1, 4'd3);
    issue_item(CMD_LOOKUP_POS, '0, '0, 4'd4);
    issue_item(CMD_LOOKUP_POS, '0, '0, 4'd15);
    issue_item(CMD_REMOVE, 32'd5, '0, '0);
    issue_item(CMD_REMOVE, 32'd77, '0, '0);
    // fill up, then one insert too many
    for (int unsigned i = 0; i < 13; i++) begin
      issue_item(CMD_INSERT, KEY_W'($urandom_range(0, 9)), VAL_W'($urandom), '0);
    end
    issue_item(CMD_INSERT, 32'd3, 32'd3, '0);

    // random mixes, mode switched with entries present
    write_mode(1'b0);
    mixed_commands(160, 60);
    mixed_commands(160, 25);
    write_mode(1'b1);
    calm = 1'b1;
    mixed_commands(160, 60);
    calm = 1'b0;
    write_mode(1'b0);
    mixed_commands(160, 45);
    write_mode(1'b1);
    mixed_commands(160, 30);
    write_mode(1'b0);
    mixed_commands(130, 50);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
